@@ rtl/core/mcsd_pkg.sv @@
// Shared types and constants for the mapping cost swap delta block.
// No dependencies; mcsd_ctrl, mcsd_datapath, the top level and the checker import this package.
package mcsd_pkg;

   localparam int OP_W    = 3;
   localparam int INDEX_W = 6;
   localparam int PLACE_W = 6;
   localparam int VALUE_W = 32;
   localparam int COST_W  = 64;
   localparam int COUNT_W = 7;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

   typedef enum logic [OP_W-1:0] {
      OP_WR_COMM   = 3'd0,
      OP_WR_DIST   = 3'd1,
      OP_WR_PLACE  = 3'd2,
      OP_FULL_COST = 3'd3,
      OP_SWAP_COST = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_ROWCAP,
      ST_BCAP,
      ST_COL,
      ST_STEP,
      ST_DRAIN
   } state_type;

   typedef enum logic [1:0] {
      PSEL_ROW,
      PSEL_J,
      PSEL_X
   } place_sel_type;

   typedef struct packed {
      logic          accept;
      logic          full;
      logic          swap;
      logic          place_rd;
      place_sel_type place_sel;
      logic          row_start;
      logic          a_cap;
      logic          b_cap;
      logic          step;
      logic          inc_x;
      logic          inc_row;
      logic          rsp_load;
   } cmd_type;

   typedef struct packed {
      logic swap_ok;
      logic n_zero;
      logic k_last;
      logic x_last;
      logic row_last;
      logic pipe_empty;
   } status_type;

endpackage

@@ rtl/core/mcsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mcsd_ctrl.sv @@
// Sequencer for the mapping cost swap delta block.
// Depends on mcsd_pkg; drives mcsd_datapath through cmd_type.
module mcsd_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [mcsd_pkg::OP_W-1:0]   req_op,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  mcsd_pkg::status_type        status,
   output mcsd_pkg::cmd_type           cmd
);
   import mcsd_pkg::*;

   state_type state_ff, state_in;
   logic      full_ff, full_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      full_in      = full_ff;
      cmd          = '0;
      req_ready    = (state_ff == ST_IDLE);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (op_type'(req_op))
                  OP_FULL_COST: begin
                     cmd.full = 1'b1;
                     full_in  = 1'b1;
                     state_in = status.n_zero ? ST_DRAIN : ST_ROW;
                  end
                  OP_SWAP_COST: begin
                     cmd.swap = 1'b1;
                     full_in  = 1'b0;
                     state_in = status.swap_ok ? ST_ROW : ST_DRAIN;
                  end
                  default: ;
               endcase
            end
         end
         ST_ROW: begin
            cmd.place_rd  = 1'b1;
            cmd.place_sel = PSEL_ROW;
            cmd.row_start = 1'b1;
            state_in      = ST_ROWCAP;
         end
         ST_ROWCAP: begin
            cmd.a_cap = 1'b1;
            if (full_ff) begin
               state_in = ST_COL;
            end else begin
               cmd.place_rd  = 1'b1;
               cmd.place_sel = PSEL_J;
               state_in      = ST_BCAP;
            end
         end
         ST_BCAP: begin
            cmd.b_cap = 1'b1;
            state_in  = ST_COL;
         end
         ST_COL: begin
            cmd.place_rd  = 1'b1;
            cmd.place_sel = PSEL_X;
            state_in      = ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (status.k_last) begin
               if (!status.x_last) begin
                  cmd.inc_x = 1'b1;
                  state_in  = ST_COL;
               end else if (full_ff && !status.row_last) begin
                  cmd.inc_row = 1'b1;
                  state_in    = ST_ROW;
               end else begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty && (!rsp_valid_ff || rsp_ready)) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/mcsd_datapath.sv @@
// Tables, placement store, multiply-accumulate pipeline and result register.
// Depends on mcsd_pkg and mcsd_ram; steered by mcsd_ctrl.
module mcsd_datapath #(
   parameter int MAX_NODES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [mcsd_pkg::COUNT_W-1:0]   csr_node_count,
   input  logic [mcsd_pkg::OP_W-1:0]      req_op,
   input  logic [mcsd_pkg::INDEX_W-1:0]   req_first_index,
   input  logic [mcsd_pkg::INDEX_W-1:0]   req_second_index,
   input  logic [mcsd_pkg::VALUE_W-1:0]   req_entry_value,
   input  logic [mcsd_pkg::COST_W-1:0]    req_base_cost,
   output logic [mcsd_pkg::COST_W-1:0]    rsp_cost,
   input  mcsd_pkg::cmd_type              cmd,
   output mcsd_pkg::status_type           status
);
   import mcsd_pkg::*;

   localparam int AW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);

   logic [COUNT_W-1:0] node_count_ff;
   logic [CW-1:0]      n;
   logic               full_ff;
   logic [AW-1:0]      i_ff, j_ff;
   logic [PLACE_W-1:0] a_ff, b_ff;
   logic [CW-1:0]      x_ff;
   logic [2:0]         k_ff;
   logic [COST_W-1:0]  acc_ff, prod_ff, rsp_cost_ff;
   logic               s1_valid_ff, s1_neg_ff, s1_zero_ff;
   logic               s2_valid_ff, s2_neg_ff;

   logic [AW-1:0]      x_idx, pidx, cu, cv, place_rd_addr;
   logic [PLACE_W-1:0] q, r_node, m, t, du, dv;
   logic               first_ok, second_ok, dist_zero, mask;
   logic               wr_comm, wr_dist, wr_place;
   logic [VALUE_W-1:0] comm_rd, dist_rd;
   logic [PLACE_W-1:0] place_rd_data_w;

   // Active node count, clipped to the store size
   always_comb begin
      n = (32'(node_count_ff) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_ff);
   end

   assign first_ok  = 32'(req_first_index) < MAX_NODES;
   assign second_ok = 32'(req_second_index) < MAX_NODES;
   assign wr_comm   = cmd.accept && (op_type'(req_op) == OP_WR_COMM) && first_ok && second_ok;
   assign wr_dist   = cmd.accept && (op_type'(req_op) == OP_WR_DIST) && first_ok && second_ok;
   assign wr_place  = cmd.accept && (op_type'(req_op) == OP_WR_PLACE) && first_ok;

   assign x_idx = x_ff[AW-1:0];
   assign q     = place_rd_data_w;

   always_comb begin
      case (cmd.place_sel)
         PSEL_ROW: place_rd_addr = i_ff;
         PSEL_J:   place_rd_addr = j_ff;
         PSEL_X:   place_rd_addr = x_idx;
         default:  place_rd_addr = x_idx;
      endcase
   end

   // Operand selection for the eight terms of a swap step; full cost uses term zero
   always_comb begin
      if (x_idx == i_ff) begin
         r_node = b_ff;
      end else if (x_idx == j_ff) begin
         r_node = a_ff;
      end else begin
         r_node = q;
      end
      m         = (k_ff[0] ^ k_ff[2]) ? b_ff : a_ff;
      t         = k_ff[2] ? r_node : q;
      du        = k_ff[1] ? t : m;
      dv        = k_ff[1] ? m : t;
      pidx      = k_ff[0] ? j_ff : i_ff;
      cu        = k_ff[1] ? x_idx : pidx;
      cv        = k_ff[1] ? pidx : x_idx;
      dist_zero = (32'(du) >= MAX_NODES) || (32'(dv) >= MAX_NODES);
      mask      = full_ff && (x_idx == i_ff);
   end

   mcsd_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_NODES * MAX_NODES)) u_comm (
      .clock   (clock),
      .wr_en   (wr_comm),
      .wr_addr ({AW'(req_first_index), AW'(req_second_index)}),
      .wr_data (req_entry_value),
      .rd_en   (cmd.step),
      .rd_addr ({cu, cv}),
      .rd_data (comm_rd)
   );

   mcsd_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_NODES * MAX_NODES)) u_dist (
      .clock   (clock),
      .wr_en   (wr_dist),
      .wr_addr ({AW'(req_first_index), AW'(req_second_index)}),
      .wr_data (req_entry_value),
      .rd_en   (cmd.step),
      .rd_addr ({AW'(du), AW'(dv)}),
      .rd_data (dist_rd)
   );

   mcsd_ram #(.WIDTH(PLACE_W), .DEPTH(MAX_NODES)) u_place (
      .clock   (clock),
      .wr_en   (wr_place),
      .wr_addr (AW'(req_first_index)),
      .wr_data (req_entry_value[PLACE_W-1:0]),
      .rd_en   (cmd.place_rd),
      .rd_addr (place_rd_addr),
      .rd_data (place_rd_data_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            node_count_ff <= csr_node_count;
         end
         s1_valid_ff <= cmd.step;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         full_ff <= cmd.full;
         if (cmd.full) begin
            i_ff <= '0;
         end else begin
            i_ff <= AW'(req_first_index);
            j_ff <= AW'(req_second_index);
         end
      end else if (cmd.inc_row) begin
         i_ff <= i_ff + 1'b1;
      end
      if (cmd.a_cap) begin
         a_ff <= q;
      end
      if (cmd.b_cap) begin
         b_ff <= q;
      end
      if (cmd.row_start) begin
         x_ff <= '0;
      end else if (cmd.inc_x) begin
         x_ff <= x_ff + 1'b1;
      end
      if (cmd.place_rd && (cmd.place_sel == PSEL_X)) begin
         k_ff <= '0;
      end else if (cmd.step) begin
         k_ff <= k_ff + 1'b1;
      end
      s1_neg_ff  <= !full_ff && !k_ff[2];
      s1_zero_ff <= dist_zero || mask;
      prod_ff    <= s1_zero_ff ? '0 : (COST_W'(comm_rd) * COST_W'(dist_rd));
      s2_neg_ff  <= s1_neg_ff;
      if (cmd.accept && cmd.full) begin
         acc_ff <= '0;
      end else if (cmd.accept && cmd.swap) begin
         acc_ff <= req_base_cost;
      end else if (s2_valid_ff) begin
         acc_ff <= s2_neg_ff ? (acc_ff - prod_ff) : (acc_ff + prod_ff);
      end
      if (cmd.rsp_load) begin
         rsp_cost_ff <= acc_ff;
      end
   end

   always_comb begin
      status.swap_ok    = (32'(req_first_index) < 32'(n)) && (32'(req_second_index) < 32'(n));
      status.n_zero     = (n == '0);
      status.k_last     = full_ff || (k_ff == 3'd7);
      status.x_last     = (32'(x_ff) + 1) == 32'(n);
      status.row_last   = (32'(i_ff) + 1) == 32'(n);
      status.pipe_empty = !s1_valid_ff && !s2_valid_ff;
   end

   assign rsp_cost = rsp_cost_ff;

endmodule

@@ rtl/core/mapping_cost_swap_delta_top.sv @@
// Top level of the mapping cost swap delta block.
// Depends on mcsd_pkg, mcsd_ctrl, mcsd_datapath and mcsd_ram.
//
// Holds a communication table C, a distance table D (MAX_NODES x MAX_NODES
// words of 32 bits each, in RAM) and a placement p of MAX_NODES entries.
// Ops 0 to 2 write one entry and give no result; ops 5 to
// 7 are dropped. Op 3 returns the full cost, the sum over i != j of
// C[i][j] * D[p[i]][p[j]]; op 4 returns base_cost plus the change that
// swapping p[i] and p[j] would make. Sums wrap modulo 2^64. With n the
// active node count (csr_node_count clipped to MAX_NODES), a full cost
// covers n rows of n columns and a swap n columns: one read port on
// each RAM gives one product per cycle while stepping, and each column
// first fetches its placement entry in a state of its own. A swap with
// an index not below n returns base_cost. Items are accepted one at a time;
// a result waits in an output register, so the next item may be taken
// while it is pending. Tables need no clearing: read only entries that
// were written. Write node_count only while the block is idle.
module mapping_cost_swap_delta_top #(
   parameter int MAX_NODES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mcsd_pkg::OP_W-1:0]      req_op,
   input  logic [mcsd_pkg::INDEX_W-1:0]   req_first_index,
   input  logic [mcsd_pkg::INDEX_W-1:0]   req_second_index,
   input  logic [mcsd_pkg::VALUE_W-1:0]   req_entry_value,
   input  logic [mcsd_pkg::COST_W-1:0]    req_base_cost,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mcsd_pkg::COST_W-1:0]    rsp_cost,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mcsd_pkg::COUNT_W-1:0]   csr_node_count
);
   import mcsd_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The register takes a write in any cycle
   assign csr_ready = 1'b1;

   mcsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mcsd_datapath #(.MAX_NODES(MAX_NODES)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_node_count   (csr_node_count),
      .req_op           (req_op),
      .req_first_index  (req_first_index),
      .req_second_index (req_second_index),
      .req_entry_value  (req_entry_value),
      .req_base_cost    (req_base_cost),
      .rsp_cost         (rsp_cost),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

@@ rtl/core/mcsd_checker.sv @@
// Port-level checks for mapping_cost_swap_delta_top, bound to it below.
// Depends on mcsd_pkg.
module mcsd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [mcsd_pkg::OP_W-1:0]      req_op,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [mcsd_pkg::COST_W-1:0]    rsp_cost,
   input logic                           csr_ready
);
   import mcsd_pkg::*;

   // Hold a pending result until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cost))
      else $error("result dropped or changed while stalled");

   // No result straight out of reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A write item never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid &&
      (req_op == OP_WR_COMM || req_op == OP_WR_DIST || req_op == OP_WR_PLACE)
      |=> !rsp_valid)
      else $error("write item produced a result");

   // A query blocks further items while it runs
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_FULL_COST || req_op == OP_SWAP_COST)
      |=> !req_ready)
      else $error("item accepted during a query");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port stalled");

endmodule

bind mapping_cost_swap_delta_top mcsd_checker u_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for mapping_cost_swap_delta_top: table and placement writes,
// full cost and swap cost queries, checked against a behavioural cost calculator.
// Depends on mcsd_pkg and the RTL under rtl/core.
module testbench;
   import mcsd_pkg::*;

   localparam int NODES = 64;
   localparam int IDLE_LIMIT = 200000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_op = '0;
   logic [INDEX_W-1:0]   req_first_index = '0;
   logic [INDEX_W-1:0]   req_second_index = '0;
   logic [VALUE_W-1:0]   req_entry_value = '0;
   logic [COST_W-1:0]    req_base_cost = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [COST_W-1:0]    rsp_cost;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [COUNT_W-1:0]   csr_node_count = '0;

   // Shadow copies of the block's stores
   logic [VALUE_W-1:0]   comm_copy [NODES*NODES];
   logic [VALUE_W-1:0]   dist_copy [NODES*NODES];
   logic [PLACE_W-1:0]   place_copy [NODES];
   logic [COUNT_W-1:0]   node_count_copy;

   logic [COST_W-1:0]    pending_costs [$];
   bit                   failed = 1'b0;
   int                   idle_cycles = 0;
   bit                   rsp_stall_long = 1'b0;

   typedef struct {
      op_type            op;
      logic [5:0]        first;
      logic [5:0]        second;
      logic [31:0]       value;
      logic [63:0]       base;
      bit                known;
      logic [63:0]       cost;
   } stim_row_type;

   mapping_cost_swap_delta_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_first_index(req_first_index), .req_second_index(req_second_index),
      .req_entry_value(req_entry_value), .req_base_cost(req_base_cost),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_cost(rsp_cost),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_node_count(csr_node_count)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int active_count();
      return (node_count_copy > NODES) ? NODES : int'(node_count_copy);
   endfunction

   function automatic logic [63:0] dist_of(int r, int c);
      return {32'd0, dist_copy[r*NODES + c]};
   endfunction

   function automatic logic [63:0] comm_of(int r, int c);
      return {32'd0, comm_copy[r*NODES + c]};
   endfunction

   function automatic logic [63:0] placement_cost();
      logic [63:0] sum;
      int n;
      sum = '0;
      n = active_count();
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++)
            if (r != c)
               sum += comm_of(r, c) * dist_of(place_copy[r], place_copy[c]);
      return sum;
   endfunction

   function automatic logic [63:0] swapped_cost(int i, int j, logic [63:0] base);
      logic [63:0] old_part, new_part;
      int n, a, b, q, r;
      n = active_count();
      old_part = '0;
      new_part = '0;
      if (i >= n || j >= n) return base;
      a = place_copy[i];
      b = place_copy[j];
      for (int x = 0; x < n; x++) begin
         q = place_copy[x];
         r = (x == i) ? b : ((x == j) ? a : q);
         old_part += comm_of(i, x) * dist_of(a, q) + comm_of(j, x) * dist_of(b, q)
                   + comm_of(x, i) * dist_of(q, a) + comm_of(x, j) * dist_of(q, b);
         new_part += comm_of(i, x) * dist_of(b, r) + comm_of(j, x) * dist_of(a, r)
                   + comm_of(x, i) * dist_of(r, b) + comm_of(x, j) * dist_of(r, a);
      end
      return base + new_part - old_part;
   endfunction

   // Cost a query would give on the current shadow stores
   function automatic logic [63:0] query_cost(logic [2:0] op, int f, int s,
                                              logic [63:0] base);
      return (op == OP_FULL_COST) ? placement_cost() : swapped_cost(f, s, base);
   endfunction

   // Update the shadow stores and queue the cost this item should produce
   task automatic account_item(logic [2:0] op, int f, int s, logic [31:0] v,
                               logic [63:0] base);
      case (op)
         OP_WR_COMM:   comm_copy[f*NODES + s] = v;
         OP_WR_DIST:   dist_copy[f*NODES + s] = v;
         OP_WR_PLACE:  place_copy[f] = v[PLACE_W-1:0];
         OP_FULL_COST: pending_costs.push_back(placement_cost());
         OP_SWAP_COST: pending_costs.push_back(swapped_cost(f, s, base));
         default: ;
      endcase
   endtask

   // Sender gap: mostly none or short, occasionally long; with no gap valid
   // stays high into the next item
   task automatic sender_gap();
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
          : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drive one item and hold it until the block takes it
   task automatic send_item(logic [2:0] op, logic [5:0] f, logic [5:0] s,
                            logic [31:0] v, logic [63:0] base);
      req_valid        <= 1'b1;
      req_op           <= op;
      req_first_index  <= f;
      req_second_index <= s;
      req_entry_value  <= v;
      req_base_cost    <= base;
      do @(posedge clock); while (!req_ready);
      account_item(op, f, s, v, base);
      sender_gap();
   endtask

   // Drop valid, wait for every pending cost, then let any in-flight work settle
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_costs.size() != 0);
      repeat (2 * NODES * NODES + 4 * NODES + 40) @(posedge clock);
   endtask

   task automatic write_node_count(logic [6:0] count);
      drain_results();
      csr_valid      <= 1'b1;
      csr_node_count <= count;
      do @(posedge clock); while (!csr_ready);
      node_count_copy = count;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Fill the first n tasks' rows and columns and the placement so nothing read is unwritten
   task automatic fill_tables(int n);
      for (int k = 0; k < n; k++)
         send_item(OP_WR_PLACE, 6'(k), 6'($urandom), 32'($urandom_range(0, n - 1)),
                   64'($urandom));
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++) begin
            send_item(OP_WR_COMM, 6'(r), 6'(c), $urandom, 64'($urandom));
            send_item(OP_WR_DIST, 6'(r), 6'(c), $urandom, 64'($urandom));
         end
   endtask

   // Full store size with swaps on positions 0 and 1 only: place every task on
   // processors 0 to 3 and fill what those swaps reach
   task automatic fill_wide();
      for (int k = 0; k < NODES; k++)
         send_item(OP_WR_PLACE, 6'(k), 6'd0, 32'($urandom_range(0, 3)), 64'($urandom));
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            send_item(OP_WR_DIST, 6'(r), 6'(c), $urandom, 64'($urandom));
      for (int r = 0; r < 2; r++)
         for (int c = 0; c < NODES; c++) begin
            send_item(OP_WR_COMM, 6'(r), 6'(c), $urandom, 64'($urandom));
            send_item(OP_WR_COMM, 6'(c), 6'(r), $urandom, 64'($urandom));
         end
   endtask

   // Receiver: stall at random, check each cost against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_costs.size() == 0) begin
               $error("unexpected result: cost %0h", rsp_cost);
               failed = 1'b1;
            end else begin
               if (rsp_cost !== pending_costs[0]) begin
                  $error("cost mismatch: expected %0h, actual %0h",
                         pending_costs[0], rsp_cost);
                  failed = 1'b1;
               end
               void'(pending_costs.pop_front());
            end
         end
         if ($urandom_range(0, 199) == 0) rsp_stall_long <= ~rsp_stall_long;
         rsp_ready <= rsp_stall_long ? ($urandom_range(0, 15) == 0)
                                     : ($urandom_range(0, 3) != 0);
      end
   end

   // Watchdog: count cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      stim_row_type rows [$];
      stim_row_type row;
      logic [6:0] counts [8];
      int n;
      bit wide_filled;
      logic [2:0] op;
      logic [5:0] f, s;
      logic [31:0] v;

      wide_filled = 1'b0;
      node_count_copy = NODE_COUNT_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: tiny node count, some all-ones entries
      write_node_count(7'd2);
      rows = '{
         '{OP_WR_PLACE, 6'd0, 6'd0, 32'hFFFF_FFC1, 64'd0, 0, 64'd0},
         '{OP_WR_PLACE, 6'd1, 6'd63, 32'd0, 64'd0, 0, 64'd0},
         '{OP_WR_COMM, 6'd0, 6'd1, 32'hFFFF_FFFF, 64'd0, 0, 64'd0},
         '{OP_WR_COMM, 6'd1, 6'd0, 32'hFFFF_FFFF, 64'd0, 0, 64'd0},
         '{OP_WR_COMM, 6'd0, 6'd0, 32'd0, 64'd0, 0, 64'd0},
         '{OP_WR_COMM, 6'd1, 6'd1, 32'd0, 64'd0, 0, 64'd0},
         '{OP_WR_DIST, 6'd1, 6'd0, 32'hFFFF_FFFF, 64'd0, 0, 64'd0},
         '{OP_WR_DIST, 6'd0, 6'd1, 32'd1, 64'd0, 0, 64'd0},
         '{OP_WR_DIST, 6'd1, 6'd1, 32'd7, 64'd0, 0, 64'd0},
         '{OP_WR_DIST, 6'd0, 6'd0, 32'd9, 64'd0, 0, 64'd0},
         '{OP_WR_DIST, 6'd63, 6'd63, 32'd5, 64'd0, 0, 64'd0},
         '{OP_WR_DIST, 6'd63, 6'd1, 32'd3, 64'd0, 0, 64'd0},
         '{OP_WR_DIST, 6'd1, 6'd63, 32'd4, 64'd0, 0, 64'd0},
         '{OP_FULL_COST, 6'd0, 6'd0, 32'd0, 64'd0, 0, 64'd0},
         '{OP_SWAP_COST, 6'd0, 6'd1, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 64'd0},
         // equal indices leave the base unchanged
         '{OP_SWAP_COST, 6'd1, 6'd1, 32'd0, 64'h1234_5678_9ABC_DEF0, 1,
           64'h1234_5678_9ABC_DEF0},
         // index out of use returns base as is
         '{OP_SWAP_COST, 6'd63, 6'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1,
           64'hFFFF_FFFF_FFFF_FFFF},
         '{OP_SWAP_COST, 6'd0, 6'd2, 32'd0, 64'd0, 1, 64'd0},
         '{op_type'(3'd5), 6'd63, 6'd63, 32'hFFFF_FFFF, '1, 0, 64'd0},
         '{op_type'(3'd6), 6'd0, 6'd0, 32'd0, 64'd0, 0, 64'd0},
         '{op_type'(3'd7), 6'd21, 6'd42, 32'hAAAA_5555, '1, 0, 64'd0}
      };
      foreach (rows[k]) begin
         row = rows[k];
         // hand-typed expectations must agree with the calculator
         if (row.known && query_cost(row.op, row.first, row.second, row.base) !== row.cost)
         begin
            $error("cost mismatch: expected %0h, actual %0h", row.cost,
                   query_cost(row.op, row.first, row.second, row.base));
            failed = 1'b1;
         end
         send_item(row.op, row.first, row.second, row.value, row.base);
      end

      // Random phases across node counts; the two full-size phases share one fill
      counts = '{7'd3, 7'd5, 7'd8, 7'd4, 7'd127, 7'd64, 7'd2, 7'd6};
      foreach (counts[p]) begin
         write_node_count(counts[p]);
         n = (counts[p] > NODES) ? NODES : int'(counts[p]);
         if (n > 8) begin
            // full-size phase: swaps on positions 0 and 1 only
            if (!wide_filled) begin
               fill_wide();
               wide_filled = 1'b1;
            end
            for (int k = 0; k < 6; k++)
               send_item(OP_SWAP_COST, 6'($urandom_range(0, 1)), 6'($urandom_range(0, 1)),
                         $urandom, {$urandom, $urandom});
            continue;
         end
         fill_tables(n);
         for (int k = 0; k < 90; k++) begin
            f = 6'($urandom_range(0, n - 1));
            s = 6'($urandom_range(0, n - 1));
            case ($urandom_range(0, 9))
               0: op = OP_WR_COMM;
               1: op = OP_WR_DIST;
               2: op = OP_WR_PLACE;
               3, 4: op = OP_FULL_COST;
               9: begin
                  op = 3'($urandom_range(4, 7));
                  f = 6'($urandom);  // may be out of use
               end
               default: op = OP_SWAP_COST;
            endcase
            v = (op == OP_WR_PLACE) ? 32'($urandom_range(0, n - 1)) : $urandom;
            send_item(op, f, s, v, {$urandom, $urandom});
            // hold off once until every pending cost is back
            if (k == 45 && p == 0) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (pending_costs.size() != 0);
            end
         end
      end

      drain_results();
      if (failed || pending_costs.size() != 0)
         $display("*** FAILED ***");
      else
         $display("*** PASSED ***");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
   end
endmodule

@@ files.f @@
rtl/core/mcsd_pkg.sv
rtl/core/mcsd_ram.sv
rtl/core/mcsd_ctrl.sv
rtl/core/mcsd_datapath.sv
rtl/core/mapping_cost_swap_delta_top.sv
rtl/core/mcsd_checker.sv
bench/testbench.sv
